FILE: src/ubxp_pkg.sv
`timescale 1ns / 1ps

package ubxp_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;
	localparam logic [7:0] ID_TIME     = 8'h21;
	localparam logic [7:0] ID_POS      = 8'h02;
	localparam logic [2:0] TIME_VALID_MASK = 3'h7;

	localparam int CAP_DEPTH = 28;
	localparam int CAP_IW    = $clog2(CAP_DEPTH);
	localparam int LEN_TIME  = 20;
	localparam int LEN_POS   = 28;

	typedef logic [CAP_DEPTH-1:0][7:0] ubxp_cap_t;

	typedef struct packed {
		logic done;
		logic good;
		logic is_pos;
		logic len_ok;
	} ubxp_frame_t;

	typedef struct packed {
		logic               check_status;
		logic               message_kind;
		logic               parse_ok;
		logic [15:0]        year;
		logic [7:0]         month;
		logic [7:0]         day;
		logic [7:0]         hour;
		logic [7:0]         minute;
		logic [7:0]         second;
		logic               time_valid;
		logic signed [31:0] longitude;
		logic signed [31:0] latitude;
	} ubxp_result_t;

endpackage

FILE: src/ubxp_framer.sv
`timescale 1ns / 1ps

module ubxp_framer #(
	parameter int MAX_PAYLOAD = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           accept_class,
	input  logic                 in_fire,
	input  logic [7:0]           rx_byte,
	output ubxp_pkg::ubxp_frame_t frame,
	output ubxp_pkg::ubxp_cap_t   cap
);
	import ubxp_pkg::*;

	localparam int LW = $clog2(MAX_PAYLOAD + 1);

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_SYNC,
		ST_CLASS,
		ST_ID,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_PAYLOAD,
		ST_CK_A,
		ST_CK_B
	} state_t;

	state_t          state_q;
	logic [7:0]      id_q;
	logic [7:0]      len_lo_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   idx_q;
	logic [7:0]      sum_a_q;
	logic [7:0]      sum_b_q;
	logic [7:0]      ck_a_q;
	ubxp_cap_t       cap_q;

	logic [15:0]     len16;
	logic [7:0]      sum_a_nx;
	logic [7:0]      sum_b_nx;
	logic [LW-1:0]   idx_nx;

	assign len16    = {rx_byte, len_lo_q};
	assign sum_a_nx = sum_a_q + rx_byte;
	assign sum_b_nx = sum_b_q + sum_a_nx;
	assign idx_nx   = idx_q + LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_HUNT;
			id_q     <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
			idx_q    <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			ck_a_q   <= '0;
		end else if (in_fire) begin
			unique case (state_q)
				ST_HUNT: begin
					if (rx_byte == SYNC_FIRST) state_q <= ST_SYNC;
				end
				ST_SYNC: begin
					if (rx_byte == SYNC_SECOND) state_q <= ST_CLASS;
					else if (rx_byte != SYNC_FIRST) state_q <= ST_HUNT;
				end
				ST_CLASS: begin
					if (rx_byte == accept_class) begin
						sum_a_q <= rx_byte;
						sum_b_q <= rx_byte;
						state_q <= ST_ID;
					end else begin
						state_q <= ST_HUNT;
					end
				end
				ST_ID: begin
					if (rx_byte == ID_TIME || rx_byte == ID_POS) begin
						id_q    <= rx_byte;
						sum_a_q <= sum_a_nx;
						sum_b_q <= sum_b_nx;
						state_q <= ST_LEN_LO;
					end else begin
						state_q <= ST_HUNT;
					end
				end
				ST_LEN_LO: begin
					len_lo_q <= rx_byte;
					sum_a_q  <= sum_a_nx;
					sum_b_q  <= sum_b_nx;
					state_q  <= ST_LEN_HI;
				end
				ST_LEN_HI: begin
					if ({1'b0, len16} > 17'(MAX_PAYLOAD)) begin
						state_q <= ST_HUNT;
					end else begin
						len_q   <= len16[LW-1:0];
						idx_q   <= '0;
						sum_a_q <= sum_a_nx;
						sum_b_q <= sum_b_nx;
						state_q <= (len16 == 16'd0) ? ST_CK_A : ST_PAYLOAD;
					end
				end
				ST_PAYLOAD: begin
					sum_a_q <= sum_a_nx;
					sum_b_q <= sum_b_nx;
					idx_q   <= idx_nx;
					if (idx_nx == len_q) state_q <= ST_CK_A;
				end
				ST_CK_A: begin
					ck_a_q  <= rx_byte;
					state_q <= ST_CK_B;
				end
				ST_CK_B: begin
					state_q <= ST_HUNT;
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

	// first bytes of the payload, read at fixed places only
	always_ff @(posedge clk) begin
		if (in_fire && state_q == ST_PAYLOAD && idx_q < LW'(CAP_DEPTH)) begin
			cap_q[idx_q[CAP_IW-1:0]] <= rx_byte;
		end
	end

	always_comb begin
		frame.done   = in_fire && (state_q == ST_CK_B);
		frame.good   = (ck_a_q == sum_a_q) && (rx_byte == sum_b_q);
		frame.is_pos = (id_q == ID_POS);
		frame.len_ok = frame.is_pos ? (len_q == LW'(LEN_POS)) : (len_q == LW'(LEN_TIME));
	end

	assign cap = cap_q;

endmodule

FILE: src/ubxp_decode.sv
`timescale 1ns / 1ps

module ubxp_decode (
	input  ubxp_pkg::ubxp_frame_t  frame,
	input  ubxp_pkg::ubxp_cap_t    cap,
	output ubxp_pkg::ubxp_result_t result
);
	import ubxp_pkg::*;

	logic ok;

	assign ok = frame.good && frame.len_ok;

	always_comb begin
		result              = '0;
		result.check_status = !frame.good;
		result.message_kind = frame.is_pos;
		result.parse_ok     = ok;
		if (ok && !frame.is_pos) begin
			result.year       = {cap[13], cap[12]};
			result.month      = cap[14];
			result.day        = cap[15];
			result.hour       = cap[16];
			result.minute     = cap[17];
			result.second     = cap[18];
			result.time_valid = (cap[19][2:0] == TIME_VALID_MASK);
		end else if (ok) begin
			result.longitude = {cap[7], cap[6], cap[5], cap[4]};
			result.latitude  = {cap[11], cap[10], cap[9], cap[8]};
		end
	end

endmodule

FILE: src/ubx_nav_frame_parser.sv
`timescale 1ns / 1ps

// byte-serial parser for navigation frames with a fletcher-8 check
// input channel: one received byte per item on rx_byte, in_valid / in_ready
// output channel: one item per completed frame (after the second check byte),
//   out_valid / out_ready, checksum status, kind, date and time or position
// accept_class is written through cfg_wr_en / cfg_wr_data by the user only while idle; the block does not check it
// throughput: one byte every cycle while in_ready is high; the frame state machine and running sums
//   update in the cycle the byte is taken
// latency: the result item is valid the cycle after the last check byte
// the result register frees in_ready whenever it is empty or being taken,
//   so a stalled receiver only holds the input while a result waits
// reset: parser hunts for sync, accept_class returns to 1, no item pending
// frames with a length above MAX_PAYLOAD or with a wrong class or id are
//   dropped without an item
module ubx_nav_frame_parser #(
	parameter int MAX_PAYLOAD = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               check_status,
	output logic               message_kind,
	output logic               parse_ok,
	output logic [15:0]        year,
	output logic [7:0]         month,
	output logic [7:0]         day,
	output logic [7:0]         hour,
	output logic [7:0]         minute,
	output logic [7:0]         second,
	output logic               time_valid,
	output logic signed [31:0] longitude,
	output logic signed [31:0] latitude
);
	import ubxp_pkg::*;

	logic         [7:0] accept_class_q;
	logic               out_valid_q;
	ubxp_result_t       res_q;
	logic               in_fire;
	ubxp_frame_t        frame;
	ubxp_cap_t          cap;
	ubxp_result_t       result;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_class_q <= 8'd1;
		end else if (cfg_wr_en) begin
			accept_class_q <= cfg_wr_data;
		end
	end

	ubxp_framer #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_framer (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept_class (accept_class_q),
		.in_fire      (in_fire),
		.rx_byte      (rx_byte),
		.frame        (frame),
		.cap          (cap)
	);

	ubxp_decode u_decode (
		.frame  (frame),
		.cap    (cap),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.done) begin
			res_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign check_status = res_q.check_status;
	assign message_kind = res_q.message_kind;
	assign parse_ok     = res_q.parse_ok;
	assign year         = res_q.year;
	assign month        = res_q.month;
	assign day          = res_q.day;
	assign hour         = res_q.hour;
	assign minute       = res_q.minute;
	assign second       = res_q.second;
	assign time_valid   = res_q.time_valid;
	assign longitude    = res_q.longitude;
	assign latitude     = res_q.latitude;

endmodule

FILE: tb/tb_ubx_nav_frame_parser.sv
`timescale 1ns / 1ps

module tb_ubx_nav_frame_parser;
	import ubxp_pkg::*;

	localparam int MAX_LEN = 256;
	localparam logic [7:0] RESET_CLASS = 8'h01;
	localparam logic [7:0] BAD_ID = 8'h03;
	localparam logic [7:0] PHASE_CLASS [5] = '{8'h00, 8'hFF, SYNC_FIRST, SYNC_SECOND, 8'h01};
	localparam int PHASE_BYTES = 180;

	typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAND, FILL_EDGE} fill_t;

	typedef struct {
		int           lead_n;
		logic [7:0]   lead_b;
		logic [7:0]   cls;
		logic [7:0]   id;
		logic [15:0]  len;
		fill_t        fill;
		bit           bad_a;
		bit           bad_b;
		int           cut;
		bit           typed;
		ubxp_result_t want;
	} frame_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [7:0]         cfg_wr_data = 8'h00;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = 8'h00;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               check_status;
	logic               message_kind;
	logic               parse_ok;
	logic [15:0]        year;
	logic [7:0]         month;
	logic [7:0]         day;
	logic [7:0]         hour;
	logic [7:0]         minute;
	logic [7:0]         second;
	logic               time_valid;
	logic signed [31:0] longitude;
	logic signed [31:0] latitude;

	// frame tracker state
	logic [7:0]  class_sel = RESET_CLASS;
	logic [17:0] frame_pos = '0;
	logic [7:0]  id_seen = '0;
	logic [7:0]  len_lo = '0;
	logic [15:0] pay_len = '0;
	logic [7:0]  fl_a = '0;
	logic [7:0]  fl_b = '0;
	logic [7:0]  rx_ck_a = '0;
	logic [7:0]  cap [CAP_DEPTH];

	ubxp_result_t frame_reports [$];
	int           mismatch_count = 0;
	int           items_sent = 0;
	int           burst_left = 0;
	bit           gaps_on = 1'b1;
	logic [15:0]  stall_pat = 16'hFFFF;
	logic [5:0]   stall_step = '0;

	frame_row_t plan [18] = '{
		'{0, 8'h00, RESET_CLASS, ID_TIME, 16'd20, FILL_ZERO, 1'b0, 1'b0, 0, 1'b1,
			'{1'b0, 1'b0, 1'b1, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'sd0, 32'sd0}},
		'{0, 8'h00, RESET_CLASS, ID_TIME, 16'd20, FILL_ONES, 1'b0, 1'b0, 0, 1'b1,
			'{1'b0, 1'b0, 1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 32'sd0, 32'sd0}},
		'{0, 8'h00, RESET_CLASS, ID_POS, 16'd28, FILL_ONES, 1'b0, 1'b0, 0, 1'b1,
			'{1'b0, 1'b1, 1'b1, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
			32'shFFFFFFFF, 32'shFFFFFFFF}},
		'{0, 8'h00, RESET_CLASS, ID_POS, 16'd28, FILL_EDGE, 1'b0, 1'b0, 0, 1'b1,
			'{1'b0, 1'b1, 1'b1, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0,
			32'sh80000000, 32'sh7FFFFFFF}},
		// repeated sync byte
		'{2, SYNC_FIRST, RESET_CLASS, ID_TIME, 16'd20, FILL_RAND, 1'b0, 1'b0, 0, 1'b0, '0},
		// checksum errors
		'{0, 8'h00, RESET_CLASS, ID_TIME, 16'd20, FILL_RAND, 1'b1, 1'b0, 0, 1'b1,
			'{1'b1, 1'b0, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'sd0, 32'sd0}},
		'{0, 8'h00, RESET_CLASS, ID_POS, 16'd28, FILL_RAND, 1'b0, 1'b1, 0, 1'b1,
			'{1'b1, 1'b1, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'sd0, 32'sd0}},
		// length does not fit the kind
		'{0, 8'h00, RESET_CLASS, ID_TIME, 16'd28, FILL_RAND, 1'b0, 1'b0, 0, 1'b1,
			'{1'b0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'sd0, 32'sd0}},
		'{0, 8'h00, RESET_CLASS, ID_POS, 16'd20, FILL_RAND, 1'b0, 1'b0, 0, 1'b1,
			'{1'b0, 1'b1, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'sd0, 32'sd0}},
		'{0, 8'h00, RESET_CLASS, ID_POS, 16'd0, FILL_RAND, 1'b0, 1'b0, 0, 1'b1,
			'{1'b0, 1'b1, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'sd0, 32'sd0}},
		// wrong class equal to the sync byte, then a stray second sync byte, then a wrong id
		'{0, 8'h00, SYNC_FIRST, ID_TIME, 16'd20, FILL_RAND, 1'b0, 1'b0, 3, 1'b0, '0},
		'{1, SYNC_SECOND, RESET_CLASS, ID_POS, 16'd28, FILL_RAND, 1'b0, 1'b0, 0, 1'b0, '0},
		'{0, 8'h00, RESET_CLASS, BAD_ID, 16'd20, FILL_RAND, 1'b0, 1'b0, 4, 1'b0, '0},
		// oversized lengths and a length at the MAX_LEN limit
		'{0, 8'h00, RESET_CLASS, ID_POS, 16'd257, FILL_RAND, 1'b0, 1'b0, 6, 1'b0, '0},
		'{0, 8'h00, RESET_CLASS, ID_TIME, 16'd256, FILL_RAND, 1'b0, 1'b0, 0, 1'b1,
			'{1'b0, 1'b0, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'sd0, 32'sd0}},
		'{0, 8'h00, RESET_CLASS, ID_TIME, 16'hFFFF, FILL_RAND, 1'b0, 1'b0, 6, 1'b0, '0},
		// payload past the capture window, then one that just fills it after lead bytes
		'{0, 8'h00, RESET_CLASS, ID_POS, 16'd29, FILL_RAND, 1'b0, 1'b0, 0, 1'b1,
			'{1'b0, 1'b1, 1'b0, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 32'sd0, 32'sd0}},
		'{3, 8'h00, RESET_CLASS, ID_POS, 16'd28, FILL_RAND, 1'b0, 1'b0, 0, 1'b0, '0}
	};

	ubx_nav_frame_parser #(
		.MAX_PAYLOAD(MAX_LEN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.check_status(check_status),
		.message_kind(message_kind),
		.parse_ok(parse_ok),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.time_valid(time_valid),
		.longitude(longitude),
		.latitude(latitude)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic void note_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s expected %0h got %0h", $realtime, what, exp_v, act_v);
	endfunction

	function automatic void fold(input logic [7:0] c);
		fl_a = fl_a + c;
		fl_b = fl_b + fl_a;
	endfunction

	function automatic void track_byte(input logic [7:0] c, output bit done,
			output ubxp_result_t r);
		logic [17:0] stop_at;
		int idx;
		bit good, ok, is_pos;
		stop_at = 18'd6 + pay_len;
		done = 1'b0;
		r = '0;
		case (frame_pos)
			18'd0: if (c == SYNC_FIRST) frame_pos = 18'd1;
			18'd1: frame_pos = (c == SYNC_SECOND) ? 18'd2 : (c == SYNC_FIRST) ? 18'd1 : 18'd0;
			18'd2: if (c == class_sel) begin
				fl_a = c;
				fl_b = c;
				frame_pos = 18'd3;
			end else begin
				frame_pos = 18'd0;
			end
			18'd3: if (c == ID_TIME || c == ID_POS) begin
				id_seen = c;
				fold(c);
				frame_pos = 18'd4;
			end else begin
				frame_pos = 18'd0;
			end
			18'd4: begin
				len_lo = c;
				fold(c);
				frame_pos = 18'd5;
			end
			18'd5: begin
				pay_len = {c, len_lo};
				if (pay_len > MAX_LEN) begin
					frame_pos = 18'd0;
				end else begin
					fold(c);
					foreach (cap[i]) cap[i] = 8'h00;
					frame_pos = 18'd6;
				end
			end
			default: if (frame_pos < stop_at) begin
				idx = int'(frame_pos) - 6;
				if (idx < CAP_DEPTH) cap[idx] = c;
				fold(c);
				frame_pos = frame_pos + 18'd1;
			end else if (frame_pos == stop_at) begin
				rx_ck_a = c;
				frame_pos = frame_pos + 18'd1;
			end else begin
				good = (rx_ck_a == fl_a) && (c == fl_b);
				is_pos = (id_seen == ID_POS);
				ok = good && (pay_len == (is_pos ? LEN_POS : LEN_TIME));
				r.check_status = !good;
				r.message_kind = is_pos;
				r.parse_ok = ok;
				if (ok && !is_pos) begin
					r.year = {cap[13], cap[12]};
					r.month = cap[14];
					r.day = cap[15];
					r.hour = cap[16];
					r.minute = cap[17];
					r.second = cap[18];
					r.time_valid = (cap[19][2:0] == TIME_VALID_MASK);
				end else if (ok) begin
					r.longitude = {cap[7], cap[6], cap[5], cap[4]};
					r.latitude = {cap[11], cap[10], cap[9], cap[8]};
				end
				frame_pos = 18'd0;
				done = 1'b1;
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed, input ubxp_result_t want);
		bit done;
		ubxp_result_t r;
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) burst_left--;
		items_sent++;
		track_byte(b, done, r);
		if (done) frame_reports.push_back(typed ? want : r);
	endtask

	task automatic send_frame(input frame_row_t fr);
		logic [7:0] bytes [$];
		logic [7:0] ck_a, ck_b, v;
		int n;
		ck_a = '0;
		ck_b = '0;
		repeat (fr.lead_n) bytes.push_back(fr.lead_b);
		bytes.push_back(SYNC_FIRST);
		bytes.push_back(SYNC_SECOND);
		bytes.push_back(fr.cls);
		bytes.push_back(fr.id);
		bytes.push_back(fr.len[7:0]);
		bytes.push_back(fr.len[15:8]);
		if (fr.cut == 0) begin
			for (int i = 0; i < int'(fr.len); i++) begin
				case (fr.fill)
					FILL_ZERO: v = 8'h00;
					FILL_ONES: v = 8'hFF;
					FILL_EDGE: begin
						case (i)
							4, 5, 6: v = 8'h00;
							7: v = 8'h80;
							8, 9, 10: v = 8'hFF;
							11: v = 8'h7F;
							default: v = 8'($urandom);
						endcase
					end
					default: v = 8'($urandom);
				endcase
				bytes.push_back(v);
			end
			for (int i = fr.lead_n + 2; i < bytes.size(); i++) begin
				ck_a = ck_a + bytes[i];
				ck_b = ck_b + ck_a;
			end
			bytes.push_back(fr.bad_a ? ck_a ^ 8'($urandom_range(1, 255)) : ck_a);
			bytes.push_back(fr.bad_b ? ck_b ^ 8'($urandom_range(1, 255)) : ck_b);
			n = bytes.size();
		end else begin
			n = fr.lead_n + fr.cut;
		end
		for (int i = 0; i < n; i++) send_byte(bytes[i], fr.typed && i == n - 1, fr.want);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (frame_reports.size() != 0);
	endtask

	task automatic write_class(input logic [7:0] v);
		drain();
		repeat (3) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		class_sel = v;
	endtask

	// receiver with its own stall pattern, checks every accepted result item
	always @(posedge clk) begin : rx_side
		ubxp_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_reports.size() == 0) begin
				note_mismatch("result item with none expected", 64'd0, 64'd1);
			end else begin
				want = frame_reports.pop_front();
				if (check_status !== want.check_status)
					note_mismatch("check_status", want.check_status, check_status);
				if (message_kind !== want.message_kind)
					note_mismatch("message_kind", want.message_kind, message_kind);
				if (parse_ok !== want.parse_ok)
					note_mismatch("parse_ok", want.parse_ok, parse_ok);
				if (year !== want.year) note_mismatch("year", want.year, year);
				if (month !== want.month) note_mismatch("month", want.month, month);
				if (day !== want.day) note_mismatch("day", want.day, day);
				if (hour !== want.hour) note_mismatch("hour", want.hour, hour);
				if (minute !== want.minute) note_mismatch("minute", want.minute, minute);
				if (second !== want.second) note_mismatch("second", want.second, second);
				if (time_valid !== want.time_valid)
					note_mismatch("time_valid", want.time_valid, time_valid);
				if (longitude !== want.longitude)
					note_mismatch("longitude", want.longitude, longitude);
				if (latitude !== want.latitude)
					note_mismatch("latitude", want.latitude, latitude);
			end
		end
		if (stall_step == 6'd63)
			stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		stall_step <= stall_step + 6'd1;
		out_ready <= stall_pat[stall_step[3:0]];
	end

	initial begin
		frame_row_t fr;
		int pick, lsel, rb, phase_end;
		logic [7:0] w;
		foreach (cap[i]) cap[i] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) send_frame(plan[r]);

		for (int ph = 0; ph < 6; ph++) begin
			write_class(ph < 5 ? PHASE_CLASS[ph] : 8'($urandom));
			gaps_on = (ph != 2);
			phase_end = items_sent + PHASE_BYTES;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				fr = '{0, 8'h00, class_sel, ID_TIME, 16'd20, FILL_RAND, 1'b0, 1'b0, 0, 1'b0, '0};
				if ($urandom_range(0, 1)) fr.id = ID_POS;
				if (pick < 6) begin
					// line noise
					repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0, '0);
				end else begin
					if (pick < 12) begin
						fr.cls = class_sel ^ 8'($urandom_range(1, 255));
						fr.cut = 3;
					end else if (pick < 16) begin
						w = 8'($urandom);
						if (w == ID_TIME || w == ID_POS) w = w ^ 8'h80;
						fr.id = w;
						fr.cut = 4;
					end else if (pick < 20) begin
						fr.len = 16'($urandom_range(MAX_LEN + 1, 65535));
						fr.cut = 6;
					end else if (pick < 22) begin
						fr.cut = $urandom_range(1, 5);
					end else begin
						lsel = $urandom_range(0, 99);
						if (lsel < 70)
							fr.len = (fr.id == ID_POS) ? 16'(LEN_POS) : 16'(LEN_TIME);
						else if (lsel < 96)
							fr.len = 16'($urandom_range(0, 40));
						else
							fr.len = 16'($urandom_range(41, MAX_LEN));
						rb = $urandom_range(0, 99);
						fr.bad_a = (rb < 5);
						fr.bad_b = (rb >= 5 && rb < 10);
						if ($urandom_range(0, 19) == 0) begin
							fr.lead_n = $urandom_range(1, 3);
							fr.lead_b = SYNC_FIRST;
						end
					end
					send_frame(fr);
				end
				// hold off until every pending result item is out
				if ($urandom_range(0, 14) == 0) drain();
			end
		end

		drain();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: files.f
src/ubxp_pkg.sv
src/ubxp_framer.sv
src/ubxp_decode.sv
src/ubx_nav_frame_parser.sv
tb/tb_ubx_nav_frame_parser.sv
